// File: sv/sac_pkg.sv
// shared types and constants for the set-associative cache simulator
// geometry, config register indexes, set row layout and fsm states
// no dependencies
`default_nettype none

package sac_pkg;

  localparam int MAX_SET_INDEX_BITS = 8;
  localparam int MAX_WAYS           = 8;
  localparam int ADDR_WIDTH         = 64;

  localparam int NUM_SETS  = 1 << MAX_SET_INDEX_BITS;
  localparam int WAY_BITS  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_BITS = WAY_BITS;
  localparam int EFF_W     = $clog2(MAX_WAYS + 1);
  localparam int TAG_W     = ADDR_WIDTH;

  // fixed field widths of the channels and registers
  localparam int ADDR_IN_W    = 64;
  localparam int ACTION_W     = 2;
  localparam int CNT_W        = 32;
  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int TOTAL_W      = 7;

  localparam logic [RANK_BITS-1:0] RANK_MAX = RANK_BITS'(MAX_WAYS - 1);
  localparam logic [CNT_W-1:0]     CNT_SAT  = '1;

  // action codes; the unused code behaves as a load
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd4;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]       WAYS_USED_RST  = 4'd1;

  typedef struct packed {
    logic [SET_BITS_W-1:0]   set_bits;
    logic [BLOCK_BITS_W-1:0] block_bits;
    logic [WAYS_W-1:0]       ways_used;
  } cfg_t;

  // one set, stored as a single memory row
  typedef struct packed {
    logic [MAX_WAYS-1:0]                valid;
    logic [MAX_WAYS-1:0][RANK_BITS-1:0] rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]     tag;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic hit;
    logic miss;
    logic evicted;
  } lru_flags_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_UPDATE
  } state_t;

endpackage

`default_nettype wire

// File: sv/sac_if.sv
// request and response channel interfaces of the cache simulator
// depends on sac_pkg
`default_nettype none

interface sac_req_if;
  import sac_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [ADDR_IN_W-1:0] address;

  modport source (output valid, action, address, input ready);
  modport sink   (input valid, action, address, output ready);
endinterface

interface sac_rsp_if;
  import sac_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic             miss;
  logic             evicted;
  logic             last_of_access;
  logic [CNT_W-1:0] hits_so_far;
  logic [CNT_W-1:0] misses_so_far;
  logic [CNT_W-1:0] evictions_so_far;

  modport source (output valid, hit, miss, evicted, last_of_access, hits_so_far,
                  misses_so_far, evictions_so_far, input ready);
  modport sink   (input valid, hit, miss, evicted, last_of_access, hits_so_far,
                  misses_so_far, evictions_so_far, output ready);
endinterface

`default_nettype wire

// File: sv/set_assoc_cache_lru_sim.sv
// top level of the set-associative cache hit/miss simulator with exact lru
// depends on sac_pkg, sac_if, sac_ram, sac_addr_split, sac_lru
//
// usage:
//   req carries one access (action, address). load and store make one
//   response, modify makes two, the second with last_of_access set.
//   each response has hit/miss/evicted flags and saturating running totals.
//   cfg_we/cfg_index/cfg_data write set_bits, block_bits, ways_used; write
//   them only while no request is in flight.
// sequence:
//   a request is taken in the idle state; the set row is read in S_READ,
//   then looked up, updated and written back in S_UPDATE, which also loads
//   the response register; S_UPDATE waits while a response is still held.
//   a modify then returns to S_READ for its second access, which rereads
//   the row, while a load or store returns to the idle state.
// reset: counters clear, config returns to 4/4/1, and a valid bit per set
//   marks every set empty at once, so no clearing pass is needed.
// stall: a held response blocks only the write-back step; the next request
//   is still taken and read while the response waits.
`default_nettype none

module set_assoc_cache_lru_sim (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sac_pkg::CFG_DATA_W-1:0] cfg_data,
  sac_req_if.sink                            req,
  sac_rsp_if.source                          rsp
);
  import sac_pkg::*;

  cfg_t cfg;
  logic [EFF_W-1:0] eff_ways;

  state_t state;
  state_t state_next;

  logic [MAX_SET_INDEX_BITS-1:0] split_set;
  logic [TAG_W-1:0]              split_tag;
  logic [MAX_SET_INDEX_BITS-1:0] set_q;
  logic [TAG_W-1:0]              tag_q;
  logic                          modify_q;
  logic                          second_q;

  logic [NUM_SETS-1:0] row_valid;
  logic [ROW_W-1:0]    ram_rdata;
  row_t                row_rd;
  row_t                row_in;
  row_t                row_new;
  lru_flags_t          lu;

  logic req_fire;
  logic upd_fire;
  logic last_now;

  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] evict_cnt;
  logic [CNT_W-1:0] hit_cnt_next;
  logic [CNT_W-1:0] miss_cnt_next;
  logic [CNT_W-1:0] evict_cnt_next;

  logic             out_valid;
  lru_flags_t       out_flags;
  logic             out_last;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_bits   <= SET_BITS_RST;
      cfg.block_bits <= BLOCK_BITS_RST;
      cfg.ways_used  <= WAYS_USED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS:   cfg.set_bits   <= cfg_data[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: cfg.block_bits <= cfg_data[BLOCK_BITS_W-1:0];
        CFG_WAYS_USED:  cfg.ways_used  <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg.ways_used == '0) begin
      eff_ways = EFF_W'(1);
    end else if (EFF_W'(cfg.ways_used) > EFF_W'(MAX_WAYS)) begin
      eff_ways = EFF_W'(MAX_WAYS);
    end else begin
      eff_ways = EFF_W'(cfg.ways_used);
    end
  end

  sac_addr_split u_split (
    .address (req.address),
    .cfg     (cfg),
    .set_idx (split_set),
    .tag     (split_tag)
  );

  // fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_UPDATE;
      S_UPDATE: begin
        if (upd_fire) begin
          state_next = (modify_q && !second_q) ? S_READ : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == S_IDLE);
    upd_fire  = (state == S_UPDATE) && (!out_valid || rsp.ready);
  end

  assign req_fire = req.valid && req.ready;
  assign last_now = !(modify_q && !second_q);

  always_ff @(posedge clk) begin
    if (req_fire) begin
      set_q    <= split_set;
      tag_q    <= split_tag;
      modify_q <= (req.action == ACT_MODIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_q <= 1'b0;
    end else if (req_fire) begin
      second_q <= 1'b0;
    end else if (upd_fire) begin
      second_q <= 1'b1;
    end
  end

  // set memory; the read in S_READ returns in S_UPDATE
  sac_ram #(
    .WIDTH      (ROW_W),
    .DEPTH_BITS (MAX_SET_INDEX_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (upd_fire),
    .waddr (set_q),
    .wdata (row_new),
    .raddr (set_q),
    .rdata (ram_rdata)
  );

  // a set never written reads as empty with zero ranks
  always_comb begin
    row_rd = row_t'(ram_rdata);
    row_in = row_rd;
    if (!row_valid[set_q]) begin
      row_in.valid = '0;
      row_in.rank  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (upd_fire) begin
      row_valid[set_q] <= 1'b1;
    end
  end

  sac_lru u_lru (
    .row      (row_in),
    .tag      (tag_q),
    .ways     (eff_ways),
    .row_next (row_new),
    .flags    (lu)
  );

  // saturating totals
  always_comb begin
    hit_cnt_next   = hit_cnt;
    miss_cnt_next  = miss_cnt;
    evict_cnt_next = evict_cnt;
    if (lu.hit && hit_cnt != CNT_SAT) begin
      hit_cnt_next = hit_cnt + CNT_W'(1);
    end
    if (lu.miss && miss_cnt != CNT_SAT) begin
      miss_cnt_next = miss_cnt + CNT_W'(1);
    end
    if (lu.evicted && evict_cnt != CNT_SAT) begin
      evict_cnt_next = evict_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      evict_cnt <= '0;
    end else if (upd_fire) begin
      hit_cnt   <= hit_cnt_next;
      miss_cnt  <= miss_cnt_next;
      evict_cnt <= evict_cnt_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_flags <= lu;
      out_last  <= last_now;
    end
  end

  always_comb begin
    rsp.valid            = out_valid;
    rsp.hit              = out_flags.hit;
    rsp.miss             = out_flags.miss;
    rsp.evicted          = out_flags.evicted;
    rsp.last_of_access   = out_last;
    rsp.hits_so_far      = hit_cnt;
    rsp.misses_so_far    = miss_cnt;
    rsp.evictions_so_far = evict_cnt;
  end

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    upd_fire |-> (!out_valid || rsp.ready))
    else $error("response register overwritten while held");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && lu.hit) |=>
      (hit_cnt == $past(hit_cnt) + CNT_W'(1)) || ($past(hit_cnt) == CNT_SAT))
    else $error("hit total did not advance on a hit");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && lu.evicted) |-> (lu.miss && !lu.hit))
    else $error("eviction reported without a miss");

  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    upd_fire |=> row_valid[$past(set_q)])
    else $error("written set not marked valid");

  a_modify_second: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && modify_q && !second_q) |=> (state == S_READ))
    else $error("modify did not issue its second access");

endmodule

`default_nettype wire

// File: sv/sac_ram.sv
// generic single-port-write, single-port-read ram, registered read data
// no dependencies
`default_nettype none

module sac_ram #(
  parameter int WIDTH      = 8,
  parameter int DEPTH_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [DEPTH_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [DEPTH_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [(1 << DEPTH_BITS)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/sac_addr_split.sv
// splits a byte address into set index and tag under the current config
// depends on sac_pkg
`default_nettype none

module sac_addr_split (
  input  wire logic [sac_pkg::ADDR_IN_W-1:0]          address,
  input  wire sac_pkg::cfg_t                          cfg,
  output logic      [sac_pkg::MAX_SET_INDEX_BITS-1:0] set_idx,
  output logic      [sac_pkg::TAG_W-1:0]              tag
);
  import sac_pkg::*;

  logic [ADDR_WIDTH-1:0]         a;
  logic [SET_BITS_W-1:0]         sb;
  logic [TOTAL_W-1:0]            total;
  logic [ADDR_WIDTH-1:0]         shifted;
  logic [MAX_SET_INDEX_BITS-1:0] set_mask;

  always_comb begin
    a  = address[ADDR_WIDTH-1:0];
    // oversized set_bits saturate
    sb = (cfg.set_bits > SET_BITS_W'(MAX_SET_INDEX_BITS))
         ? SET_BITS_W'(MAX_SET_INDEX_BITS) : cfg.set_bits;
    total    = TOTAL_W'(cfg.block_bits) + TOTAL_W'(sb);
    shifted  = a >> cfg.block_bits;
    set_mask = ~({MAX_SET_INDEX_BITS{1'b1}} << sb);
    set_idx  = shifted[MAX_SET_INDEX_BITS-1:0] & set_mask;
    tag      = (total >= TOTAL_W'(ADDR_WIDTH)) ? '0 : TAG_W'(a >> total);
  end

endmodule

`default_nettype wire

// File: sv/sac_lru.sv
// tag lookup, victim choice and lru rank update for one set row
// depends on sac_pkg
`default_nettype none

module sac_lru (
  input  wire sac_pkg::row_t                  row,
  input  wire logic [sac_pkg::TAG_W-1:0]      tag,
  input  wire logic [sac_pkg::EFF_W-1:0]      ways,
  output sac_pkg::row_t                       row_next,
  output sac_pkg::lru_flags_t                 flags
);
  import sac_pkg::*;

  logic [MAX_WAYS-1:0]  in_use;
  logic [MAX_WAYS-1:0]  match;
  logic                 hit_found;
  logic                 inv_found;
  logic [WAY_BITS-1:0]  hit_way;
  logic [WAY_BITS-1:0]  inv_way;
  logic [WAY_BITS-1:0]  vic_way;
  logic [RANK_BITS-1:0] best;
  logic [WAY_BITS-1:0]  w;
  logic [RANK_BITS-1:0] old_rank;

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      in_use[j] = EFF_W'(j) < ways;
      match[j]  = in_use[j] && row.valid[j] && (row.tag[j] == tag);
    end
  end

  // lowest-numbered matching way and lowest-numbered free way
  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_found = 1'b1;
        hit_way   = WAY_BITS'(j);
      end
      if (in_use[j] && !row.valid[j]) begin
        inv_found = 1'b1;
        inv_way   = WAY_BITS'(j);
      end
    end
  end

  // oldest way, lowest index on a tie
  always_comb begin
    best    = row.rank[0];
    vic_way = '0;
    for (int j = 1; j < MAX_WAYS; j++) begin
      if (in_use[j] && (row.rank[j] > best)) begin
        best    = row.rank[j];
        vic_way = WAY_BITS'(j);
      end
    end
  end

  always_comb begin
    priority if (hit_found) begin
      w = hit_way;
    end else if (inv_found) begin
      w = inv_way;
    end else begin
      w = vic_way;
    end
    old_rank = row.rank[w];

    row_next = row;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (in_use[j] && (WAY_BITS'(j) != w) && row.valid[j]
          && (!hit_found || (row.rank[j] < old_rank))
          && (row.rank[j] != RANK_MAX)) begin
        row_next.rank[j] = row.rank[j] + RANK_BITS'(1);
      end
    end
    row_next.valid[w] = 1'b1;
    row_next.rank[w]  = '0;
    row_next.tag[w]   = tag;

    flags.hit     = hit_found;
    flags.miss    = !hit_found;
    flags.evicted = !hit_found && !inv_found;
  end

endmodule

`default_nettype wire
